[src/packed_bit_vector_store_assert.svh]
// assertion macros for the packed bit vector store
`ifndef PACKED_BIT_VECTOR_STORE_ASSERT_SVH
`define PACKED_BIT_VECTOR_STORE_ASSERT_SVH

`ifndef NO_ASSERTIONS

`define PBVS_ASSERT_ALWAYS(label, cond) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
    else $error("pbvs: invariant violated");

`define PBVS_ASSERT_IMPLY(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("pbvs: implication violated");

`else

`define PBVS_ASSERT_ALWAYS(label, cond)

`define PBVS_ASSERT_IMPLY(label, ante, cons)

`endif

`endif

[src/pbvs_pkg.sv]
// shared types and constants of the packed bit vector store
`default_nettype none

package pbvs_pkg;

  localparam int CMD_W = 3;
  localparam int POS_W = 9;
  localparam int LEN_W = 9;
  localparam int ERR_W = 2;

  typedef enum logic [CMD_W-1:0] {
    CMD_APPEND = 3'd0,
    CMD_READ   = 3'd1,
    CMD_WRITE  = 3'd2,
    CMD_INSERT = 3'd3,
    CMD_ERASE  = 3'd4
  } cmd_t;

  typedef enum logic [ERR_W-1:0] {
    ERR_OK    = 2'd0,
    ERR_RANGE = 2'd1,
    ERR_FULL  = 2'd2
  } err_t;

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_READ = 5'b00010,
    S_SHR  = 5'b00100,
    S_SHW  = 5'b01000,
    S_PUT  = 5'b10000
  } state_t;

endpackage

`default_nettype wire

[src/pbvs_ram.sv]
// generic single-write, single-read ram with registered read data
`default_nettype none

module pbvs_ram #(
  parameter int WIDTH = 1,
  parameter int DEPTH = 256
) (
  input  wire logic                             clk,
  input  wire logic                             we,
  input  wire logic [$clog2(DEPTH)-1:0]         waddr,
  input  wire logic [WIDTH-1:0]                 wdata,
  input  wire logic [$clog2(DEPTH)-1:0]         raddr,
  output logic      [WIDTH-1:0]                 rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

[src/packed_bit_vector_store.sv]
// packed bit vector store: top level with command sequencer and bit memory
//
//   channel  | ports                                       | handshake
//   ---------+---------------------------------------------+-------------------------
//   command  | in_command, in_position, in_bit_value       | start high, busy low
//   result   | out_read_bit, out_length, out_error_code    | out_strobe, one cycle
//
// append, write, failed and unknown commands, insert at the end and erase of the last bit:
//   result in the cycle after accept; busy stays low so the next word can follow at once
// read: result after the registered ram read in S_READ, then the output register
// insert: each moved bit goes through S_SHR and S_SHW, then S_PUT writes the new bit;
//   erase: the same S_SHR and S_SHW pair per moved bit, with no S_PUT;
//   each moved bit costs one ram read and one ram write through one index adder
// rst_n clears the length and the sequencer; bit memory content is not cleared
// results are never held off by the receiver
`default_nettype none

`include "packed_bit_vector_store_assert.svh"

module packed_bit_vector_store #(
  parameter int CAPACITY = 256
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        start,
  output logic                             busy,
  input  wire logic [pbvs_pkg::CMD_W-1:0]  in_command,
  input  wire logic [pbvs_pkg::POS_W-1:0]  in_position,
  input  wire logic                        in_bit_value,
  output logic                             out_strobe,
  output logic                             out_read_bit,
  output logic [pbvs_pkg::LEN_W-1:0]       out_length,
  output logic [pbvs_pkg::ERR_W-1:0]       out_error_code
);

  import pbvs_pkg::*;

  localparam int AW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);
  localparam int XW = (CW > POS_W) ? CW : POS_W;

  state_t          state_r, state_nxt;
  logic [CW-1:0]   count_r, count_nxt;
  logic            op_ins_r, op_ins_nxt;
  logic [AW-1:0]   pos_r, pos_nxt;
  logic            val_r, val_nxt;
  logic [AW-1:0]   src_r, src_nxt;
  logic [AW-1:0]   dst_r, dst_nxt;
  logic [AW-1:0]   lim_r, lim_nxt;

  logic            out_strobe_r, out_strobe_nxt;
  logic            out_read_bit_r, out_read_bit_nxt;
  logic [LEN_W-1:0] out_length_r, out_length_nxt;
  logic [ERR_W-1:0] out_error_code_r, out_error_code_nxt;

  logic            in_accept;
  logic [XW-1:0]   pos_x;
  logic [XW-1:0]   cnt_x;
  logic            full;
  logic [AW-1:0]   src_step;

  logic            fin;
  logic            fin_bit;
  err_t            fin_err;

  logic            mem_we;
  logic [AW-1:0]   mem_waddr;
  logic            mem_wdata;
  logic [AW-1:0]   mem_raddr;
  logic            mem_rdata;

  assign busy      = (state_r != S_IDLE);
  assign in_accept = start && !busy;
  assign pos_x     = XW'(in_position);
  assign cnt_x     = XW'(count_r);
  assign full      = (count_r == CW'(CAPACITY));

  // shared index unit: steps down for insert, up for erase
  assign src_step  = src_r + (op_ins_r ? {AW{1'b1}} : AW'(1));

  always_comb begin
    state_nxt  = state_r;
    count_nxt  = count_r;
    op_ins_nxt = op_ins_r;
    pos_nxt    = pos_r;
    val_nxt    = val_r;
    src_nxt    = src_r;
    dst_nxt    = dst_r;
    lim_nxt    = lim_r;
    fin        = 1'b0;
    fin_bit    = 1'b0;
    fin_err    = ERR_OK;
    mem_we     = 1'b0;
    mem_waddr  = dst_r;
    mem_wdata  = mem_rdata;
    mem_raddr  = src_r;

    unique case (state_r)
      S_IDLE: begin
        if (in_accept) begin
          case (in_command)
            CMD_APPEND: begin
              fin = 1'b1;
              if (full) begin
                fin_err = ERR_FULL;
              end else begin
                mem_we    = 1'b1;
                mem_waddr = AW'(count_r);
                mem_wdata = in_bit_value;
                count_nxt = count_r + CW'(1);
              end
            end
            CMD_READ: begin
              if (pos_x >= cnt_x) begin
                fin     = 1'b1;
                fin_err = ERR_RANGE;
              end else begin
                mem_raddr = AW'(in_position);
                state_nxt = S_READ;
              end
            end
            CMD_WRITE: begin
              fin = 1'b1;
              if (pos_x >= cnt_x) begin
                fin_err = ERR_RANGE;
              end else begin
                mem_we    = 1'b1;
                mem_waddr = AW'(in_position);
                mem_wdata = in_bit_value;
              end
            end
            CMD_INSERT: begin
              if (pos_x > cnt_x) begin
                fin     = 1'b1;
                fin_err = ERR_RANGE;
              end else if (full) begin
                fin     = 1'b1;
                fin_err = ERR_FULL;
              end else if (pos_x == cnt_x) begin
                // insert at the end: nothing to move
                fin       = 1'b1;
                mem_we    = 1'b1;
                mem_waddr = AW'(in_position);
                mem_wdata = in_bit_value;
                count_nxt = count_r + CW'(1);
              end else begin
                op_ins_nxt = 1'b1;
                pos_nxt    = AW'(in_position);
                val_nxt    = in_bit_value;
                src_nxt    = AW'(count_r - CW'(1));
                dst_nxt    = AW'(count_r);
                lim_nxt    = AW'(in_position);
                state_nxt  = S_SHR;
              end
            end
            CMD_ERASE: begin
              if (pos_x >= cnt_x) begin
                fin     = 1'b1;
                fin_err = ERR_RANGE;
              end else if ((pos_x + XW'(1)) == cnt_x) begin
                // erase of the last bit: nothing to move
                fin       = 1'b1;
                count_nxt = count_r - CW'(1);
              end else begin
                op_ins_nxt = 1'b0;
                src_nxt    = AW'(in_position) + AW'(1);
                dst_nxt    = AW'(in_position);
                lim_nxt    = AW'(count_r - CW'(1));
                state_nxt  = S_SHR;
              end
            end
            default: begin
              fin = 1'b1;
            end
          endcase
        end
      end
      S_READ: begin
        fin       = 1'b1;
        fin_bit   = mem_rdata;
        state_nxt = S_IDLE;
      end
      S_SHR: begin
        state_nxt = S_SHW;
      end
      S_SHW: begin
        mem_we    = 1'b1;
        mem_waddr = dst_r;
        mem_wdata = mem_rdata;
        dst_nxt   = src_r;
        src_nxt   = src_step;
        if (src_r == lim_r) begin
          if (op_ins_r) begin
            state_nxt = S_PUT;
          end else begin
            fin       = 1'b1;
            count_nxt = count_r - CW'(1);
            state_nxt = S_IDLE;
          end
        end else begin
          state_nxt = S_SHR;
        end
      end
      S_PUT: begin
        mem_we    = 1'b1;
        mem_waddr = pos_r;
        mem_wdata = val_r;
        count_nxt = count_r + CW'(1);
        fin       = 1'b1;
        state_nxt = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    out_strobe_nxt     = fin;
    out_read_bit_nxt   = fin_bit;
    out_length_nxt     = LEN_W'(count_nxt);
    out_error_code_nxt = fin_err;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      count_r      <= '0;
      out_strobe_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      count_r      <= count_nxt;
      out_strobe_r <= out_strobe_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_ins_r         <= op_ins_nxt;
    pos_r            <= pos_nxt;
    val_r            <= val_nxt;
    src_r            <= src_nxt;
    dst_r            <= dst_nxt;
    lim_r            <= lim_nxt;
    out_read_bit_r   <= out_read_bit_nxt;
    out_length_r     <= out_length_nxt;
    out_error_code_r <= out_error_code_nxt;
  end

  pbvs_ram #(
    .WIDTH (1),
    .DEPTH (CAPACITY)
  ) u_ram (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  assign out_strobe     = out_strobe_r;
  assign out_read_bit   = out_read_bit_r;
  assign out_length     = out_length_r;
  assign out_error_code = out_error_code_r;

  `PBVS_ASSERT_ALWAYS(a_count_le_cap, count_r <= CW'(CAPACITY))
  `PBVS_ASSERT_IMPLY(a_count_moves_with_result, count_r != $past(count_r), out_strobe_r)
  `PBVS_ASSERT_IMPLY(a_write_follows_read, state_r == S_SHW, $past(state_r == S_SHR))
  `PBVS_ASSERT_IMPLY(a_waddr_in_range, mem_we, {1'b0, mem_waddr} < (AW + 1)'(CAPACITY))

endmodule

`default_nettype wire

[verif/packed_bit_vector_store_tb.sv]
// self-checking testbench for the packed bit vector store
`timescale 1ns / 1ps

module packed_bit_vector_store_tb;
  import pbvs_pkg::*;

  localparam int CAPACITY    = 256;
  localparam int POS_MAX     = (1 << POS_W) - 1;
  localparam int CYCLE_LIMIT = 6_000_000;

  typedef struct {
    logic             read_bit;
    logic [LEN_W-1:0] length;
    err_t             error_code;
  } result_t;

  logic             clk;
  logic             rst_n        = 1'b0;
  logic             start        = 1'b0;
  logic [CMD_W-1:0] in_command   = '0;
  logic [POS_W-1:0] in_position  = '0;
  logic             in_bit_value = 1'b0;
  logic             busy;
  logic             out_strobe;
  logic             out_read_bit;
  logic [LEN_W-1:0] out_length;
  logic [ERR_W-1:0] out_error_code;

  // shadow copy of the bit sequence
  logic        stored_bits [0:CAPACITY-1];
  int unsigned stored_len = 0;
  result_t     pending_results[$];
  int          mismatches = 0;

  packed_bit_vector_store #(
    .CAPACITY(CAPACITY)
  ) uut (
    .clk           (clk),
    .rst_n         (rst_n),
    .start         (start),
    .busy          (busy),
    .in_command    (in_command),
    .in_position   (in_position),
    .in_bit_value  (in_bit_value),
    .out_strobe    (out_strobe),
    .out_read_bit  (out_read_bit),
    .out_length    (out_length),
    .out_error_code(out_error_code)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    repeat (CYCLE_LIMIT) @(posedge clk);
    $display("timeout after %0d cycles, %0d results outstanding", CYCLE_LIMIT,
             pending_results.size());
    $display("*** FAILED ***");
    $finish;
  end

  // updates the shadow sequence and returns the result word the command should give
  function automatic result_t apply_command(logic [CMD_W-1:0] cmd, logic [POS_W-1:0] pos,
                                            logic val);
    result_t r;
    int      i;
    r.read_bit   = 1'b0;
    r.error_code = ERR_OK;
    case (cmd)
      CMD_APPEND: begin
        if (stored_len >= CAPACITY) begin
          r.error_code = ERR_FULL;
        end else begin
          stored_bits[stored_len] = val;
          stored_len++;
        end
      end
      CMD_READ: begin
        if (pos >= stored_len) r.error_code = ERR_RANGE;
        else r.read_bit = stored_bits[pos];
      end
      CMD_WRITE: begin
        if (pos >= stored_len) r.error_code = ERR_RANGE;
        else stored_bits[pos] = val;
      end
      CMD_INSERT: begin
        // range check wins over the full check
        if (pos > stored_len) begin
          r.error_code = ERR_RANGE;
        end else if (stored_len >= CAPACITY) begin
          r.error_code = ERR_FULL;
        end else begin
          for (i = stored_len; i > pos; i--) stored_bits[i] = stored_bits[i-1];
          stored_bits[pos] = val;
          stored_len++;
        end
      end
      CMD_ERASE: begin
        if (pos >= stored_len) begin
          r.error_code = ERR_RANGE;
        end else begin
          for (i = pos + 1; i < stored_len; i++) stored_bits[i-1] = stored_bits[i];
          stored_len--;
        end
      end
      default: ;
    endcase
    r.length = LEN_W'(stored_len);
    return r;
  endfunction

  always @(posedge clk) begin
    result_t want;
    if (rst_n && out_strobe !== 1'b0) begin
      if (pending_results.size() == 0) begin
        $error("result word with nothing pending: length %0d error_code %0d",
               out_length, out_error_code);
        mismatches++;
      end else begin
        want = pending_results.pop_front();
        if (out_read_bit !== want.read_bit) begin
          $error("read_bit: expected %0d, got %0d", want.read_bit, out_read_bit);
          mismatches++;
        end
        if (out_length !== want.length) begin
          $error("length: expected %0d, got %0d", want.length, out_length);
          mismatches++;
        end
        if (out_error_code !== want.error_code) begin
          $error("error_code: expected %0d, got %0d", want.error_code, out_error_code);
          mismatches++;
        end
      end
    end
  end

  // start stays high on return so the next word can follow without a gap
  task automatic issue_command(input logic [CMD_W-1:0] cmd, input logic [POS_W-1:0] pos,
                               input logic val);
    start        <= 1'b1;
    in_command   <= cmd;
    in_position  <= pos;
    in_bit_value <= val;
    @(posedge clk);
    while (busy !== 1'b0) @(posedge clk);
    pending_results.insert(pending_results.size(), apply_command(cmd, pos, val));
  endtask

  task automatic pause_sender(input int cycles);
    start <= 1'b0;
    repeat (cycles) @(posedge clk);
  endtask

  task automatic wait_for_results();
    start <= 1'b0;
    do @(posedge clk); while (pending_results.size() != 0);
  endtask

  function automatic logic [POS_W-1:0] random_position();
    int sel;
    int back;
    sel = $urandom_range(0, 99);
    if (sel < 50) begin
      // close to the end keeps shifts short
      back = $urandom_range(0, 4);
      if (back > stored_len) back = stored_len;
      return POS_W'(stored_len - back);
    end
    if (sel < 70) return POS_W'($urandom_range(0, stored_len));
    if (sel < 85) return POS_W'($urandom_range(stored_len + 1, POS_MAX));
    case ($urandom_range(0, 3))
      0:       return '0;
      1:       return POS_W'(CAPACITY - 1);
      2:       return POS_W'(CAPACITY);
      default: return POS_W'(POS_MAX);
    endcase
  endfunction

  // steers the length toward a target so that it sweeps the whole range
  function automatic logic [CMD_W-1:0] random_command(int unsigned target);
    int sel;
    sel = $urandom_range(0, 99);
    if (sel < 5) return CMD_W'($urandom_range(int'(CMD_ERASE) + 1, (1 << CMD_W) - 1));
    if (sel < 25) return CMD_READ;
    if (sel < 40) return CMD_WRITE;
    if (sel < ((stored_len < target) ? 90 : 50)) begin
      return $urandom_range(0, 1) ? CMD_APPEND : CMD_INSERT;
    end
    return CMD_ERASE;
  endfunction

  task automatic test_directed_corners();
    int c;
    // empty store
    issue_command(CMD_READ, '0, 1'b0);
    issue_command(CMD_WRITE, '0, 1'b1);
    issue_command(CMD_ERASE, '0, 1'b0);
    issue_command(CMD_INSERT, 9'd1, 1'b1);
    issue_command(CMD_INSERT, POS_W'(POS_MAX), 1'b1);
    issue_command(CMD_READ, POS_W'(POS_MAX), 1'b1);
    for (c = int'(CMD_ERASE) + 1; c < (1 << CMD_W); c++) begin
      issue_command(CMD_W'(c), POS_W'(POS_MAX), 1'b1);
    end
    issue_command(CMD_INSERT, '0, 1'b1);
    issue_command(CMD_APPEND, POS_W'(POS_MAX), 1'b0);
    issue_command(CMD_APPEND, '0, 1'b1);
    // insert right at the end, then in the middle
    issue_command(CMD_INSERT, 9'd3, 1'b0);
    issue_command(CMD_INSERT, 9'd1, 1'b1);
    issue_command(CMD_READ, '0, 1'b0);
    issue_command(CMD_READ, 9'd4, 1'b0);
    issue_command(CMD_READ, 9'd5, 1'b0);
    issue_command(CMD_WRITE, 9'd4, 1'b1);
    issue_command(CMD_READ, 9'd4, 1'b0);
    issue_command(CMD_ERASE, '0, 1'b1);
    issue_command(CMD_ERASE, 9'd3, 1'b0);
    issue_command(CMD_ERASE, 9'd1, 1'b1);
    issue_command(CMD_READ, 9'd1, 1'b0);
  endtask

  task automatic test_fill_and_drain();
    int unsigned pos;
    while (stored_len < CAPACITY) begin
      issue_command(CMD_APPEND, POS_W'($urandom_range(0, POS_MAX)), 1'($urandom_range(0, 1)));
    end
    issue_command(CMD_APPEND, '0, 1'b1);
    issue_command(CMD_INSERT, POS_W'(CAPACITY), 1'b1);
    issue_command(CMD_INSERT, POS_W'(CAPACITY + 1), 1'b0);
    issue_command(CMD_INSERT, '0, 1'b1);
    issue_command(CMD_READ, POS_W'(CAPACITY - 1), 1'b0);
    issue_command(CMD_READ, POS_W'(CAPACITY), 1'b0);
    issue_command(CMD_WRITE, POS_W'(CAPACITY - 1), 1'($urandom_range(0, 1)));
    issue_command(CMD_WRITE, POS_W'(POS_MAX), 1'b1);
    issue_command(CMD_ERASE, POS_W'(CAPACITY), 1'b0);
    // full-length shifts both ways
    issue_command(CMD_ERASE, '0, 1'b0);
    issue_command(CMD_READ, '0, 1'b0);
    issue_command(CMD_INSERT, '0, 1'($urandom_range(0, 1)));
    issue_command(CMD_READ, '0, 1'b0);
    issue_command(CMD_READ, POS_W'(CAPACITY - 1), 1'b0);
    issue_command(CMD_ERASE, POS_W'(CAPACITY - 1), 1'b1);
    while (stored_len > 0) begin
      pos = ($urandom_range(0, 7) == 0) ? $urandom_range(0, stored_len - 1) : stored_len - 1;
      issue_command(CMD_ERASE, POS_W'(pos), 1'($urandom_range(0, 1)));
    end
    issue_command(CMD_ERASE, '0, 1'b1);
    issue_command(CMD_APPEND, '0, 1'b1);
  endtask

  task automatic test_random_traffic(input int words, input int idle_pct);
    int          k;
    int unsigned target;
    target = stored_len;
    for (k = 0; k < words; k++) begin
      if (k % 200 == 0) begin
        case ($urandom_range(0, 3))
          0:       target = $urandom_range(0, 12);
          1:       target = $urandom_range(40, 200);
          2:       target = $urandom_range(244, CAPACITY);
          default: target = CAPACITY / 2;
        endcase
      end
      if (idle_pct != 0 && $urandom_range(1, 100) <= idle_pct) begin
        pause_sender($urandom_range(1, 16));
      end
      issue_command(random_command(target), random_position(), 1'($urandom_range(0, 1)));
    end
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    test_directed_corners();
    wait_for_results();
    test_fill_and_drain();
    wait_for_results();
    test_random_traffic(400, 25);
    wait_for_results();
    test_random_traffic(300, 0);
    test_random_traffic(400, 60);
    wait_for_results();
    // closing stretch at full rate
    test_random_traffic(300, 0);
    wait_for_results();
    repeat (16) @(posedge clk);
    if (mismatches == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

[filelist.f]
+incdir+src
src/pbvs_pkg.sv
src/pbvs_ram.sv
src/packed_bit_vector_store.sv
verif/packed_bit_vector_store_tb.sv
